FILE: rtl/gsd_pkg.sv
// ----------------------------------------------------------------------------
// gsd_pkg
// Shared widths, register indexes, reset values and types of the gyro shake
// detector.
// ----------------------------------------------------------------------------
package gsd_pkg;

  // configuration register widths
  localparam int THR_W    = 32;
  localparam int STREAK_W = 8;
  localparam int ARM_W    = 32;
  localparam int COOL_W   = 16;
  localparam int GAP_W    = 16;

  // timestamp field width on the input transfer
  localparam int NOW_W = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // result transfer: shake, locked, streak_count padded to whole bytes
  localparam int OUT_BITS = 2 + STREAK_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_THRESHOLD_SQ = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAK_NEEDED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_UNTIL_MS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP_MS        = 3'd4;

  // register reset values
  localparam logic [THR_W-1:0]    RST_SPIN_THRESHOLD_SQ = 32'd368640000;
  localparam logic [STREAK_W-1:0] RST_STREAK_NEEDED     = 8'd5;
  localparam logic [ARM_W-1:0]    RST_ARM_UNTIL_MS      = 32'd2000;
  localparam logic [COOL_W-1:0]   RST_COOLDOWN_MS       = 16'd2800;
  localparam logic [GAP_W-1:0]    RST_MIN_GAP_MS        = 16'd850;

  // streak saturation point
  localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

  // one result item
  typedef struct packed {
    logic [STREAK_W-1:0] streak_count;
    logic                locked;
    logic                shake;
  } gsd_result_t;

endpackage

FILE: rtl/gyro_shake_detector_core.sv
// ----------------------------------------------------------------------------
// gyro_shake_detector_core
// Gyro shake detector: squared magnitude threshold, loud-sample streak,
// arm-time and cooldown lockout, minimum gap between triggers.
// ----------------------------------------------------------------------------
// Latency: two register stages; the accepting edge loads the input register,
// a later edge with a free result register loads the result register, and
// the state update sits between them.
// Throughput: one sample per cycle while the result side does not stall.
// Reset: synchronous rst clears both valid flags and the detector state and
// loads the configuration registers with their default values.
module gyro_shake_detector_core
  import gsd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 32,
  localparam int IN_BITS = 3 * SAMPLE_BITS + NOW_W,
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // sample stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,   // rate_x, rate_y, rate_z, now_ms, zero pad
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // shake, locked, streak_count, zero pad
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [THR_W-1:0]     spin_threshold_sq;
  logic [STREAK_W-1:0]  streak_needed;
  logic [TIME_BITS-1:0] arm_until_ms;
  logic [COOL_W-1:0]    cooldown_ms;
  logic [GAP_W-1:0]     min_gap_ms;

  logic                          in_valid;
  logic signed [SAMPLE_BITS-1:0] rate_x;
  logic signed [SAMPLE_BITS-1:0] rate_y;
  logic signed [SAMPLE_BITS-1:0] rate_z;
  logic [TIME_BITS-1:0]          now;

  logic        advance;
  logic        step;
  logic        loud;
  gsd_result_t result;
  gsd_result_t out_result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spin_threshold_sq <= RST_SPIN_THRESHOLD_SQ;
      streak_needed     <= RST_STREAK_NEEDED;
      arm_until_ms      <= TIME_BITS'(RST_ARM_UNTIL_MS);
      cooldown_ms       <= RST_COOLDOWN_MS;
      min_gap_ms        <= RST_MIN_GAP_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPIN_THRESHOLD_SQ: spin_threshold_sq <= cfg_data[THR_W-1:0];
        CFG_STREAK_NEEDED:     streak_needed     <= cfg_data[STREAK_W-1:0];
        CFG_ARM_UNTIL_MS:      arm_until_ms      <= TIME_BITS'(cfg_data[ARM_W-1:0]);
        CFG_COOLDOWN_MS:       cooldown_ms       <= cfg_data[COOL_W-1:0];
        CFG_MIN_GAP_MS:        min_gap_ms        <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow: result register frees when empty or taken
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rate_x <= s_tdata[0*SAMPLE_BITS +: SAMPLE_BITS];
      rate_y <= s_tdata[1*SAMPLE_BITS +: SAMPLE_BITS];
      rate_z <= s_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
      now    <= TIME_BITS'(s_tdata[3*SAMPLE_BITS +: NOW_W]);
    end
  end

  // magnitude compare
  gsd_mag #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mag (
    .rate_x            (rate_x),
    .rate_y            (rate_y),
    .rate_z            (rate_z),
    .spin_threshold_sq (spin_threshold_sq),
    .loud              (loud)
  );

  // lockout, streak and trigger
  gsd_ctrl #(
    .TIME_BITS(TIME_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .loud          (loud),
    .now           (now),
    .streak_needed (streak_needed),
    .arm_until_ms  (arm_until_ms),
    .cooldown_ms   (cooldown_ms),
    .min_gap_ms    (min_gap_ms),
    .result        (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= result;
    end
  end

  assign m_tdata = OUT_W'({out_result.streak_count, out_result.locked, out_result.shake});

endmodule

FILE: rtl/gsd_mag.sv
// ----------------------------------------------------------------------------
// gsd_mag
// Squared gyro magnitude against the squared threshold.
// ----------------------------------------------------------------------------
module gsd_mag
  import gsd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  localparam int SQ_W  = 2 * SAMPLE_BITS,
  localparam int SUM_W = SQ_W + 2,
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W
) (
  input  logic signed [SAMPLE_BITS-1:0] rate_x,
  input  logic signed [SAMPLE_BITS-1:0] rate_y,
  input  logic signed [SAMPLE_BITS-1:0] rate_z,
  input  logic        [THR_W-1:0]       spin_threshold_sq,
  output logic                          loud
);

  logic signed [SQ_W-1:0] sq_x;
  logic signed [SQ_W-1:0] sq_y;
  logic signed [SQ_W-1:0] sq_z;
  logic        [SUM_W-1:0] mag_sq;

  // per-axis squares, never negative so the top bit stays clear
  assign sq_x = rate_x * rate_x;
  assign sq_y = rate_y * rate_y;
  assign sq_z = rate_z * rate_z;

  // sum with two bits of growth
  assign mag_sq = {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};

  // strictly above threshold is loud
  assign loud = CMP_W'(mag_sq) > CMP_W'(spin_threshold_sq);

endmodule

FILE: rtl/gsd_ctrl.sv
// ----------------------------------------------------------------------------
// gsd_ctrl
// Lockout, streak counting and trigger decision with the detector state.
// ----------------------------------------------------------------------------
module gsd_ctrl
  import gsd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 loud,
  input  logic [TIME_BITS-1:0] now,
  input  logic [STREAK_W-1:0]  streak_needed,
  input  logic [TIME_BITS-1:0] arm_until_ms,
  input  logic [COOL_W-1:0]    cooldown_ms,
  input  logic [GAP_W-1:0]     min_gap_ms,
  output gsd_result_t          result
);

  logic [STREAK_W-1:0]  streak;
  logic [STREAK_W-1:0]  streak_next;
  logic [TIME_BITS-1:0] last_trigger_ms;
  logic [TIME_BITS-1:0] cooldown_end_ms;

  logic [TIME_BITS-1:0] arm_diff;
  logic [TIME_BITS-1:0] gap;
  logic [STREAK_W-1:0]  needed;
  logic [STREAK_W-1:0]  streak_upd;
  logic                 before_arm;
  logic                 locked;
  logic                 trigger;

  // lockout: signed wrap compare on arm time, unsigned compare on cooldown end
  assign arm_diff   = now - arm_until_ms;
  assign before_arm = arm_diff[TIME_BITS-1];
  assign locked     = before_arm || (now < cooldown_end_ms);

  // a zero requirement acts as one
  assign needed = (streak_needed == '0) ? STREAK_W'(1) : streak_needed;
  assign gap    = now - last_trigger_ms;

  // streak update before the trigger check
  always_comb begin
    if (!loud) begin
      streak_upd = '0;
    end else if (locked || streak == STREAK_MAX) begin
      streak_upd = streak;
    end else begin
      streak_upd = streak + STREAK_W'(1);
    end
  end

  assign trigger = !locked && (streak_upd >= needed) && (gap > TIME_BITS'(min_gap_ms));
  assign streak_next = trigger ? '0 : streak_upd;

  // result of the current item
  assign result.shake        = trigger;
  assign result.locked       = locked;
  assign result.streak_count = streak_next;

  // detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      streak          <= '0;
      last_trigger_ms <= '0;
      cooldown_end_ms <= '0;
    end else if (step) begin
      streak <= streak_next;
      if (trigger) begin
        last_trigger_ms <= now;
        cooldown_end_ms <= now + TIME_BITS'(cooldown_ms);
      end
    end
  end

endmodule

FILE: rtl/gsd_checker.sv
// ----------------------------------------------------------------------------
// gsd_checker
// Port-level checks on the result stream of the gyro shake detector.
// ----------------------------------------------------------------------------
module gsd_checker
  import gsd_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // no result is pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a trigger never comes from a locked sample
  a_shake_unlocked: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[1])
    else $error("shake reported while locked");

  // the streak is cleared by a trigger
  a_shake_clears: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[2 +: STREAK_W] == '0)
    else $error("streak not cleared on shake");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind gyro_shake_detector_core gsd_checker u_gsd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: verif/gsd_checker.sv
// ----------------------------------------------------------------------------
// gsd_scoreboard
// Watches the sample, result and configuration channels of the gyro shake
// detector, keeps its own copy of the detector registers and state, predicts
// one report per accepted sample and compares each result transfer, field by
// field, with the oldest predicted report.
// ----------------------------------------------------------------------------
module gsd_scoreboard
  import gsd_pkg::*;
#(
  parameter int  RATE_W = 16,
  localparam int IN_W   = ((3 * RATE_W + NOW_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,   // rate_x, rate_y, rate_z, now_ms, zero pad
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_W-1:0]      m_tdata,   // shake, locked, streak_count, zero pad
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    checked,
  output int                    shakes
);

  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the detector registers
  logic [THR_W-1:0]    thr_sq;
  logic [STREAK_W-1:0] need_cnt;
  logic [ARM_W-1:0]    arm_ms;
  logic [COOL_W-1:0]   cool_len;
  logic [GAP_W-1:0]    gap_len;

  // shadow copy of the detector state
  logic [STREAK_W-1:0] streak;
  logic [NOW_W-1:0]    prev_hit_ms;
  logic [NOW_W-1:0]    cool_end_ms;

  // predicted reports, oldest first
  gsd_result_t reports_q[$];

  int n_mismatch = 0;
  int n_checked  = 0;
  int n_shake    = 0;

  // square of one signed rate, the most negative value included
  function automatic logic [2*RATE_W-1:0] rate_sq(input logic signed [RATE_W-1:0] v);
    logic [RATE_W-1:0] mag;
    mag = v[RATE_W-1] ? RATE_W'(-v) : RATE_W'(v);
    return mag * mag;
  endfunction

  // advance the detector by one sample and form its report
  task automatic step_detector(input logic signed [RATE_W-1:0] rx, ry, rz,
                               input logic [NOW_W-1:0] now,
                               output gsd_result_t res);
    logic [2*RATE_W+1:0] energy;
    logic [NOW_W-1:0]    since_arm;
    logic [NOW_W-1:0]    since_shake;
    logic [STREAK_W-1:0] need;
    logic                loud;
    logic                lock;
    logic                hit;
    energy      = rate_sq(rx) + rate_sq(ry) + rate_sq(rz);
    loud        = energy > thr_sq;
    since_arm   = now - arm_ms;
    lock        = since_arm[NOW_W-1] || (now < cool_end_ms);
    need        = (need_cnt == '0) ? STREAK_W'(1) : need_cnt;
    hit         = 1'b0;
    if (lock) begin
      // locked: a quiet sample still breaks the streak
      if (!loud) streak = '0;
    end else begin
      if (loud) begin
        if (streak != STREAK_MAX) streak = streak + 1'b1;
      end else begin
        streak = '0;
      end
      since_shake = now - prev_hit_ms;
      if (streak >= need && since_shake > NOW_W'(gap_len)) begin
        hit         = 1'b1;
        streak      = '0;
        prev_hit_ms = now;
        cool_end_ms = now + NOW_W'(cool_len);
      end
    end
    res.shake        = hit;
    res.locked       = lock;
    res.streak_count = streak;
  endtask

  task automatic flag_field(input string field, input logic [15:0] want,
                            input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      n_mismatch++;
    end
  endtask

  always @(posedge clk) begin
    gsd_result_t want;
    gsd_result_t seen;
    if (rst) begin
      thr_sq      = RST_SPIN_THRESHOLD_SQ;
      need_cnt    = RST_STREAK_NEEDED;
      arm_ms      = RST_ARM_UNTIL_MS;
      cool_len    = RST_COOLDOWN_MS;
      gap_len     = RST_MIN_GAP_MS;
      streak      = '0;
      prev_hit_ms = '0;
      cool_end_ms = '0;
      reports_q.delete();
    end else begin
      // register writes, upper data bits dropped
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_SPIN_THRESHOLD_SQ: thr_sq   = cfg_data[THR_W-1:0];
          CFG_STREAK_NEEDED:     need_cnt = cfg_data[STREAK_W-1:0];
          CFG_ARM_UNTIL_MS:      arm_ms   = cfg_data[ARM_W-1:0];
          CFG_COOLDOWN_MS:       cool_len = cfg_data[COOL_W-1:0];
          CFG_MIN_GAP_MS:        gap_len  = cfg_data[GAP_W-1:0];
          default: ;
        endcase
      end

      // sample transfer: predict its report
      if (s_tvalid === 1'b1 && s_tready === 1'b1) begin
        step_detector(s_tdata[RATE_W-1:0], s_tdata[2*RATE_W-1:RATE_W],
                      s_tdata[3*RATE_W-1:2*RATE_W], s_tdata[3*RATE_W +: NOW_W], want);
        reports_q.push_back(want);
      end

      // result transfer: compare with the oldest prediction
      if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
        seen = m_tdata[OUT_BITS-1:0];
        if (reports_q.size() == 0) begin
          $display("%0t ns: result with no sample outstanding, expected none, actual %h",
                   $time, m_tdata);
          n_mismatch++;
        end else begin
          want = reports_q.pop_front();
          flag_field("shake", 16'(want.shake), 16'(seen.shake));
          flag_field("locked", 16'(want.locked), 16'(seen.locked));
          flag_field("streak_count", 16'(want.streak_count), 16'(seen.streak_count));
          flag_field("pad bits", '0, 16'(m_tdata >> OUT_BITS));
          n_checked++;
          if (want.shake) n_shake++;
        end
      end
    end
    fail_count <= n_mismatch;
    pending    <= reports_q.size();
    checked    <= n_checked;
    shakes     <= n_shake;
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the gyro shake detector with directed and random gyro samples over
// a series of register settings, with random gaps on the sample side and
// random stalls on the result side; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import gsd_pkg::*;

  localparam int RATE_W   = 16;
  localparam int IN_W     = ((3 * RATE_W + NOW_W + 7) / 8) * 8;
  localparam int N_PHASES = 9;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  localparam logic signed [RATE_W-1:0] RATE_MIN    = 16'sh8000;
  localparam logic signed [RATE_W-1:0] RATE_MAX    = 16'sh7FFF;
  // square of this equals the default threshold
  localparam logic signed [RATE_W-1:0] RATE_AT_THR = 16'sd19200;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata;   // rate_x, rate_y, rate_z, now_ms, zero pad
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_W-1:0]      m_tdata;   // shake, locked, streak_count, zero pad
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;
  int shakes;

  // stimulus state
  logic [NOW_W-1:0]    sim_ms;
  logic [THR_W-1:0]    cur_thr;
  logic [STREAK_W-1:0] cur_need;
  logic                src_steady;
  logic                sink_steady;
  int                  samples_sent;
  int                  settings_used;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gyro_shake_detector_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gsd_scoreboard #(.RATE_W(RATE_W)) u_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .shakes     (shakes)
  );

  // random rate, shifted down to reach small magnitudes too
  function automatic logic signed [RATE_W-1:0] rand_rate(input int unsigned max_shift);
    logic signed [RATE_W-1:0] v;
    v = RATE_W'($urandom);
    return v >>> $urandom_range(0, max_shift);
  endfunction

  function automatic longint rate_energy(input logic signed [RATE_W-1:0] x, y, z);
    return longint'(x) * x + longint'(y) * y + longint'(z) * z;
  endfunction

  // one sample transfer, after a random gap
  task automatic put_sample(input logic signed [RATE_W-1:0] rx, ry, rz,
                            input logic [NOW_W-1:0] now);
    int unsigned gap;
    gap = src_steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {now, rz, ry, rx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    samples_sent++;
  endtask

  // rates aimed at the wanted side of the current threshold, else a fallback
  task automatic shaped_rates(input logic loud,
                              output logic signed [RATE_W-1:0] rx, ry, rz);
    for (int k = 0; k < 8; k++) begin
      rx = rand_rate(loud ? 2 : 15);
      ry = rand_rate(loud ? 2 : 15);
      rz = rand_rate(loud ? 2 : 15);
      if ((rate_energy(rx, ry, rz) > longint'(cur_thr)) == loud) return;
    end
    rx = loud ? RATE_MIN : '0;
    ry = rx;
    rz = rx;
  endtask

  // full register set, upper bits of narrow registers filled with junk
  task automatic load_regs(input logic [THR_W-1:0] thr, input logic [STREAK_W-1:0] need,
                           input logic [ARM_W-1:0] arm, input logic [COOL_W-1:0] cool,
                           input logic [GAP_W-1:0] gap_ms);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPIN_THRESHOLD_SQ;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= CFG_STREAK_NEEDED;
    cfg_data  <= {24'($urandom), need};
    @(posedge clk);
    cfg_index <= CFG_ARM_UNTIL_MS;
    cfg_data  <= arm;
    @(posedge clk);
    cfg_index <= CFG_COOLDOWN_MS;
    cfg_data  <= {16'($urandom), cool};
    @(posedge clk);
    cfg_index <= CFG_MIN_GAP_MS;
    cfg_data  <= {16'($urandom), gap_ms};
    @(posedge clk);
    cfg_index <= CFG_UNMAPPED;
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_thr  = thr;
    cur_need = need;
    settings_used++;
  endtask

  // stop sending and wait for every predicted report to come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly loud bursts and quiet breaks on a rising clock, some noise
  task automatic run_random(input int n_items, input int unsigned max_step,
                            input logic long_runs);
    int                       loud_left;
    int                       quiet_left;
    int                       burst_max;
    int                       noise_odds;
    logic                     want_loud;
    logic signed [RATE_W-1:0] rx, ry, rz;
    logic [NOW_W-1:0]         t;
    loud_left  = 0;
    quiet_left = 0;
    noise_odds = long_runs ? 50 : 10;
    burst_max  = ((cur_need == '0) ? 1 : int'(cur_need)) + 2;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) src_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(1, noise_odds) == 1) begin
        // noise: any rates, jumps and steps back in time
        rx = rand_rate(15);
        ry = rand_rate(15);
        rz = rand_rate(15);
        case ($urandom_range(0, 2))
          0:       t = $urandom;
          1:       t = sim_ms - $urandom_range(0, 2000);
          default: t = sim_ms;
        endcase
      end else begin
        sim_ms += $urandom_range(0, max_step);
        if (loud_left == 0 && quiet_left == 0) begin
          loud_left  = long_runs ? $urandom_range(256, 300) : $urandom_range(1, burst_max);
          quiet_left = $urandom_range(1, 3);
        end
        want_loud = (loud_left != 0);
        if (want_loud) loud_left--;
        else quiet_left--;
        shaped_rates(want_loud, rx, ry, rz);
        t = sim_ms;
      end
      put_sample(rx, ry, rz, t);
    end
  endtask

  // result side: random stalls per transfer, with steady stretches
  initial begin
    int unsigned stall;
    int          n_taken;
    sink_steady = 1'b0;
    n_taken     = 0;
    forever begin
      if (n_taken % 40 == 0) sink_steady = ($urandom_range(0, 3) == 0);
      stall = sink_steady ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      n_taken++;
    end
  end

  // sample side and verdict
  initial begin
    int unsigned step;
    rst           <= 1'b1;
    s_tvalid      <= 1'b0;
    s_tdata       <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_SPIN_THRESHOLD_SQ;
    cfg_data      <= '0;
    src_steady    = 1'b0;
    samples_sent  = 0;
    settings_used = 1;
    cur_thr       = RST_SPIN_THRESHOLD_SQ;
    cur_need      = RST_STREAK_NEEDED;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: arm edges, threshold edge, two triggers and the cooldown
    put_sample('0, '0, '0, 32'd0);
    put_sample(RATE_MIN, RATE_MIN, RATE_MIN, 32'd1999);
    put_sample(RATE_MAX, RATE_MAX, RATE_MAX, 32'hFFFF_FFFF);
    put_sample(RATE_MAX, '0, '0, 32'h8000_07CF);
    put_sample('0, RATE_MAX, '0, 32'h8000_07D0);
    put_sample(RATE_MIN, '0, '0, 32'd2000);
    put_sample('0, RATE_MIN, '0, 32'd2001);
    put_sample('0, '0, RATE_MIN, 32'd2002);
    put_sample(RATE_AT_THR, '0, '0, 32'd2003);
    put_sample(-RATE_AT_THR - 16'sd1, '0, '0, 32'd2004);
    put_sample(RATE_MAX, -16'sd1, -16'sd1, 32'd2005);
    put_sample(-16'sd1, RATE_MAX, -16'sd1, 32'd2006);
    put_sample(16'sh5555, 16'shAAAA, '0, 32'd2007);
    put_sample(16'shAAAA, 16'sh5555, 16'sh5555, 32'd2008);
    put_sample(RATE_MAX, RATE_MAX, RATE_MAX, 32'd2009);
    put_sample(16'sd1, 16'sd1, 16'sd1, 32'd4807);
    put_sample(RATE_MIN, RATE_MAX, RATE_MIN, 32'd4808);
    for (int k = 1; k <= 4; k++) put_sample(RATE_MIN, RATE_W'(k), '0, 32'd4808 + k);
    put_sample(-16'sd1, -16'sd1, -16'sd1, 32'h7FFF_FFFF);

    // random at the reset settings
    sim_ms = 32'd8000;
    run_random(150, 200, 1'b0);
    wait_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          // all low: armed nonzero samples fire unless at the last trigger time
          sim_ms = $urandom_range(0, 32'h7FFF_0000);
          load_regs(32'd0, 8'd1, 32'd0, 16'd0, 16'd0);
          step = 3;
        end
        1: begin
          // everything at its high end: nothing is ever loud
          sim_ms = $urandom;
          load_regs(32'hC000_0000, 8'd255, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
          step = 5000;
        end
        2: begin
          // long loud runs inside the minimum gap: streak saturates
          sim_ms = $urandom_range(0, 32'h7000_0000);
          load_regs(32'd1000, 8'd255, 32'd0, 16'd0, 16'hFFFF);
          step = 2;
        end
        3: begin
          // zero streak needed, arm time and cooldown end across the wrap
          sim_ms = 32'hFFFF_FE00;
          load_regs(RST_SPIN_THRESHOLD_SQ, 8'd0, 32'hFFFF_FF00, 16'd100, 16'd10);
          step = 20;
        end
        4: begin
          // long cooldown whose end wraps to a small value
          sim_ms = 32'hFFFF_0000;
          load_regs(RST_SPIN_THRESHOLD_SQ, 8'd3, 32'h8000_0000, 16'hFFFF, 16'd850);
          step = 400;
        end
        default: begin
          sim_ms = $urandom;
          load_regs($urandom_range(0, 32'hC000_0000) >> $urandom_range(0, 12),
                    STREAK_W'($urandom_range(1, 8)), sim_ms + $urandom_range(0, 3000),
                    COOL_W'($urandom_range(0, 3000)), GAP_W'($urandom_range(0, 1000)));
          step = $urandom_range(20, 300);
        end
      endcase
      run_random((ph == 2) ? 600 : 100, step, ph == 2);
      wait_drained();
    end

    // two-stage pipeline: let any stray result show up
    repeat (4) @(posedge clk);
    $display("summary: %0d samples over %0d register settings, %0d reports checked",
             samples_sent, settings_used, checked);
    $display("summary: %0d shakes predicted, streak saturation and time wrap exercised",
             shakes);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("timeout with %0d reports outstanding", pending);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: sim.f
rtl/gsd_pkg.sv
rtl/gsd_mag.sv
rtl/gsd_ctrl.sv
rtl/gyro_shake_detector_core.sv
rtl/gsd_checker.sv
verif/gsd_checker.sv
verif/tb_top.sv
